/* hdl/utf8v_pkg.sv */
// utf8v_pkg: shared types and byte-class constants for the utf-8 stream validator
// no dependencies; used by the byte channel interface, the validator top level and the bench

package utf8v_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] pend_t;

    // lead and continuation classification masks and patterns
    localparam byte_t ASCII_MAX   = 8'h7F;
    localparam byte_t CONT_MASK   = 8'hC0;
    localparam byte_t CONT_PAT    = 8'h80;
    localparam byte_t LEAD2_MASK  = 8'hE0;
    localparam byte_t LEAD2_PAT   = 8'hC0;
    localparam byte_t LEAD3_MASK  = 8'hF0;
    localparam byte_t LEAD3_PAT   = 8'hE0;
    localparam byte_t LEAD4_MASK  = 8'hF8;
    localparam byte_t LEAD4_PAT   = 8'hF0;
    localparam byte_t ED_LEAD     = 8'hED;
    localparam byte_t ED_BAD_MASK = 8'hA0;

    localparam pend_t PEND_NONE  = 2'd0;
    localparam pend_t PEND_ONE   = 2'd1;
    localparam pend_t PEND_TWO   = 2'd2;
    localparam pend_t PEND_THREE = 2'd3;

    // validator state carried from byte to byte
    typedef struct packed {
        pend_t pend;
        logic  after_ed;
        logic  seen_error;
    } val_state_t;

    localparam val_state_t STATE_CLEAR = '{pend: PEND_NONE, after_ed: 1'b0, seen_error: 1'b0};

endpackage

/* hdl/utf8v_byte_if.sv */
// utf8v_byte_if: valid/ready channel carrying one byte of a string per beat
// depends on utf8v_pkg for the byte type

interface utf8v_byte_if;
    logic              valid;
    logic              ready;
    utf8v_pkg::byte_t  data_byte;
    logic              byte_present;
    logic              string_end;

    modport source (output valid, output data_byte, output byte_present,
                    output string_end, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input string_end, output ready);
endinterface

/* hdl/utf8v_verdict_if.sv */
// utf8v_verdict_if: valid/ready channel carrying one string verdict per beat
// no package dependencies

interface utf8v_verdict_if;
    logic valid;
    logic ready;
    logic string_valid;

    modport source (output valid, output string_valid, input ready);
    modport sink   (input valid, input string_valid, output ready);
endinterface

/* hdl/utf8_stream_validator_unit.sv */
// utf8_stream_validator_unit: lenient utf-8 checker, one byte per beat, one verdict per string
// depends on utf8v_pkg, utf8v_byte_if and utf8v_verdict_if

// The block takes one byte per beat on byte_in and gives one verdict beat on
// verdict_out for each beat marked string_end; string_valid is 1 when the whole
// string is well formed. Leads C0-DF take one continuation byte, E0-EF two and
// F0-F7 three; overlong forms are accepted. A lead 80-BF or F8-FF, a missing
// continuation byte, a sequence cut off by the end of the string, or ED followed
// by A0-BF makes the string invalid. A beat with byte_present low and string_end
// high ends the string without a byte (an empty string is valid); a beat with
// both low is ignored. Throughput is one byte per clock while no end-of-string
// beat waits: a beat is taken into an input register, the state update and
// verdict are a few gates deep and land in the state and verdict registers, so
// a verdict is offered from the verdict register once its end-of-string beat has
// passed the input register. A waiting verdict does not stop the next bytes: only
// an end-of-string beat waits in the input register, blocking further beats, and
// only while the previous verdict is untaken.
module utf8_stream_validator_unit (
    input  logic              clk,
    input  logic              rst_n,
    utf8v_byte_if.sink        byte_in,
    utf8v_verdict_if.source   verdict_out
);

    // input register stage
    logic                  s1_valid_reg;
    utf8v_pkg::byte_t      s1_byte_reg;
    logic                  s1_present_reg;
    logic                  s1_end_reg;

    // string state and verdict register
    utf8v_pkg::val_state_t state_reg;
    utf8v_pkg::val_state_t state_next;
    utf8v_pkg::val_state_t upd;
    logic                  out_valid_reg;
    logic                  string_valid_reg;
    logic                  string_valid_next;

    logic                  out_free;
    logic                  s1_fire;
    logic                  in_fire;

    // verdict slot can take a new verdict when empty or being drained
    assign out_free = !out_valid_reg || verdict_out.ready;
    // bytes without string end never need the verdict slot
    assign s1_fire  = s1_valid_reg && (!s1_end_reg || out_free);
    assign byte_in.ready = !s1_valid_reg || s1_fire;
    assign in_fire  = byte_in.valid && byte_in.ready;

    // per-byte state update
    always_comb
    begin
        upd = state_reg;
        if (s1_present_reg && !state_reg.seen_error)
        begin
            if (state_reg.pend != utf8v_pkg::PEND_NONE)
            begin
                // continuation expected
                if (state_reg.after_ed
                    && ((s1_byte_reg & utf8v_pkg::ED_BAD_MASK) == utf8v_pkg::ED_BAD_MASK))
                begin
                    upd.seen_error = 1'b1;
                end
                else if ((s1_byte_reg & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_PAT)
                begin
                    upd.after_ed   = 1'b0;
                    upd.seen_error = 1'b1;
                end
                else
                begin
                    upd.after_ed = 1'b0;
                    upd.pend     = state_reg.pend - utf8v_pkg::PEND_ONE;
                end
            end
            else
            begin
                // lead byte classification
                priority if (s1_byte_reg <= utf8v_pkg::ASCII_MAX)
                begin
                    upd.pend = utf8v_pkg::PEND_NONE;
                end
                else if ((s1_byte_reg & utf8v_pkg::LEAD2_MASK) == utf8v_pkg::LEAD2_PAT)
                begin
                    upd.pend = utf8v_pkg::PEND_ONE;
                end
                else if ((s1_byte_reg & utf8v_pkg::LEAD3_MASK) == utf8v_pkg::LEAD3_PAT)
                begin
                    upd.pend     = utf8v_pkg::PEND_TWO;
                    upd.after_ed = (s1_byte_reg == utf8v_pkg::ED_LEAD);
                end
                else if ((s1_byte_reg & utf8v_pkg::LEAD4_MASK) == utf8v_pkg::LEAD4_PAT)
                begin
                    upd.pend = utf8v_pkg::PEND_THREE;
                end
                else
                begin
                    upd.seen_error = 1'b1;
                end
            end
        end

        string_valid_next = !upd.seen_error && (upd.pend == utf8v_pkg::PEND_NONE);
        // state clears once the verdict is formed
        state_next = s1_end_reg ? utf8v_pkg::STATE_CLEAR : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= utf8v_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_in.ready)
            begin
                s1_valid_reg <= byte_in.valid;
            end
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
            if (s1_fire && s1_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdict_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg    <= byte_in.data_byte;
            s1_present_reg <= byte_in.byte_present;
            s1_end_reg     <= byte_in.string_end;
        end
        if (s1_fire && s1_end_reg)
        begin
            string_valid_reg <= string_valid_next;
        end
    end

    assign verdict_out.valid        = out_valid_reg;
    assign verdict_out.string_valid = string_valid_reg;

    // ed flag only lives inside an open sequence
    a_ed_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.after_ed |-> (state_reg.pend != utf8v_pkg::PEND_NONE))
        else $error("ed flag set with no continuation pending");

    // error stays until the string ends
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seen_error && !(s1_fire && s1_end_reg) |=> state_reg.seen_error)
        else $error("sticky error dropped inside a string");

    // every string end yields a verdict beat
    a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_end_reg |=> out_valid_reg)
        else $error("string end without verdict");

    // an accepted beat always lands in the input register
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted beat lost");

    // a string end never overwrites an untaken verdict
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_end_reg |-> out_free)
        else $error("verdict overwritten");

endmodule

/* tb/utf8_stream_validator_unit_tb.sv */
// utf8_stream_validator_unit_tb: self-checking bench for the lenient utf-8 stream validator
// depends on utf8v_pkg, utf8v_byte_if, utf8v_verdict_if and utf8_stream_validator_unit
// byte beats are scored against an in-bench predictor of the validator, one verdict per string

module utf8_stream_validator_unit_tb;

    typedef utf8v_pkg::byte_t byte_q_t[$];

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    utf8v_byte_if    byte_ch();
    utf8v_verdict_if verdict_ch();

    utf8_stream_validator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (byte_ch),
        .verdict_out (verdict_ch)
    );

    // predictor state for the string in flight
    utf8v_pkg::pend_t pend_count;
    logic             ed_seen;
    logic             error_seen;

    // verdicts predicted but not yet seen on the output
    bit expected_verdicts[$];

    int error_count;
    int items_sent;

    // idling knobs, in percent per beat
    int tx_gap_pct;
    int rx_stall_pct;
    int noise_pct;

    // long receiver hold-off, counted down by the receiver process
    int hold_request;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // append one byte to the tail of a string
    function automatic void put_byte(ref byte_q_t str, input utf8v_pkg::byte_t b);
        str.insert(str.size(), b);
    endfunction

    // advance the predictor by one accepted beat; an end beat yields a verdict
    task automatic predict_verdict(input utf8v_pkg::byte_t d, input logic present,
                                   input logic last);
        if (present && !error_seen)
        begin
            if (pend_count != utf8v_pkg::PEND_NONE)
            begin
                // ed lead may not be followed by a0-bf (surrogate range)
                if (ed_seen
                    && ((d & utf8v_pkg::ED_BAD_MASK) == utf8v_pkg::ED_BAD_MASK))
                begin
                    error_seen = 1'b1;
                end
                else
                begin
                    ed_seen = 1'b0;
                    if ((d & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_PAT)
                        error_seen = 1'b1;
                    else
                        pend_count = pend_count - utf8v_pkg::PEND_ONE;
                end
            end
            else if (d <= utf8v_pkg::ASCII_MAX)
            begin
                // plain ascii, nothing to track
            end
            else if ((d & utf8v_pkg::LEAD2_MASK) == utf8v_pkg::LEAD2_PAT)
            begin
                pend_count = utf8v_pkg::PEND_ONE;
            end
            else if ((d & utf8v_pkg::LEAD3_MASK) == utf8v_pkg::LEAD3_PAT)
            begin
                pend_count = utf8v_pkg::PEND_TWO;
                ed_seen    = (d == utf8v_pkg::ED_LEAD);
            end
            else if ((d & utf8v_pkg::LEAD4_MASK) == utf8v_pkg::LEAD4_PAT)
            begin
                pend_count = utf8v_pkg::PEND_THREE;
            end
            else
            begin
                // stray continuation or f8-ff lead
                error_seen = 1'b1;
            end
        end
        if (last)
        begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     !error_seen && (pend_count == utf8v_pkg::PEND_NONE));
            pend_count = utf8v_pkg::PEND_NONE;
            ed_seen    = 1'b0;
            error_seen = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // offer one beat, hold it until taken, then feed the predictor
    task automatic send_beat(input utf8v_pkg::byte_t d, input logic present, input logic last);
        int gap;
        gap = ($urandom_range(99) < tx_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= d;
        byte_ch.byte_present <= present;
        byte_ch.string_end   <= last;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        predict_verdict(d, present, last);
        if (present || last)
            items_sent++;
    endtask

    // send a whole string; close_empty ends it with a beat that carries no byte
    task automatic send_string(input byte_q_t str, input bit close_empty);
        for (int i = 0; i < str.size(); i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_beat(utf8v_pkg::byte_t'($urandom_range(255)), 1'b0, 1'b0);
            send_beat(str[i], 1'b1, !close_empty && (i == str.size() - 1));
        end
        if (close_empty || str.size() == 0)
            send_beat(utf8v_pkg::byte_t'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    function automatic utf8v_pkg::byte_t cont_byte();
        return utf8v_pkg::byte_t'($urandom_range(8'h80, 8'hBF));
    endfunction

    // one well-formed character of one to four bytes
    function automatic void append_char(ref byte_q_t str);
        utf8v_pkg::byte_t lead;
        case ($urandom_range(3))
            0: put_byte(str, utf8v_pkg::byte_t'($urandom_range(8'h00, 8'h7F)));
            1:
            begin
                put_byte(str, utf8v_pkg::byte_t'($urandom_range(8'hC0, 8'hDF)));
                put_byte(str, cont_byte());
            end
            2:
            begin
                // ed gets extra weight so its restricted second byte is exercised
                lead = ($urandom_range(2) == 0)
                       ? utf8v_pkg::ED_LEAD
                       : utf8v_pkg::byte_t'($urandom_range(8'hE0, 8'hEF));
                put_byte(str, lead);
                put_byte(str, (lead == utf8v_pkg::ED_LEAD)
                              ? utf8v_pkg::byte_t'($urandom_range(8'h80, 8'h9F))
                              : cont_byte());
                put_byte(str, cont_byte());
            end
            default:
            begin
                put_byte(str, utf8v_pkg::byte_t'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) put_byte(str, cont_byte());
            end
        endcase
    endfunction

    // splice one kind of fault into an otherwise good string
    function automatic void break_string(ref byte_q_t str);
        byte_q_t frag;
        int pos;
        pos = $urandom_range(str.size());
        case ($urandom_range(3))
            0:
            begin
                // sequence at the end of the string, cut off unless a c0-df lead gets its continuation
                put_byte(frag, utf8v_pkg::byte_t'($urandom_range(8'hC0, 8'hF7)));
                if ($urandom_range(1))
                    put_byte(frag, cont_byte());
                pos = str.size();
            end
            1:
            begin
                // continuation expected, something else arrives
                put_byte(frag, utf8v_pkg::byte_t'($urandom_range(8'hC0, 8'hF7)));
                put_byte(frag, ($urandom_range(1) == 0)
                               ? utf8v_pkg::byte_t'($urandom_range(8'h00, 8'h7F))
                               : utf8v_pkg::byte_t'($urandom_range(8'hC0, 8'hFF)));
            end
            2:
            begin
                // lead byte that can never start a character
                put_byte(frag, ($urandom_range(1) == 0)
                               ? utf8v_pkg::byte_t'($urandom_range(8'h80, 8'hBF))
                               : utf8v_pkg::byte_t'($urandom_range(8'hF8, 8'hFF)));
            end
            default:
            begin
                // ed followed by a0-bf
                put_byte(frag, utf8v_pkg::ED_LEAD);
                put_byte(frag, utf8v_pkg::byte_t'($urandom_range(8'hA0, 8'hBF)));
                put_byte(frag, cont_byte());
            end
        endcase
        for (int i = frag.size() - 1; i >= 0; i--)
            str.insert(pos, frag[i]);
    endfunction

    function automatic byte_q_t random_string();
        byte_q_t str;
        int flavour;
        flavour = $urandom_range(99);
        if (flavour < 10)
        begin
            // raw noise bytes
            repeat ($urandom_range(1, 8))
                put_byte(str, utf8v_pkg::byte_t'($urandom_range(255)));
        end
        else if (flavour >= 14)
        begin
            repeat ($urandom_range(1, 5)) append_char(str);
            if (flavour >= 76)
                break_string(str);
        end
        // flavours 10-13 stay empty
        return str;
    endfunction

    // random strings until the running beat count reaches target
    task automatic send_random_strings(input int target);
        while (items_sent < target)
            send_string(random_string(), $urandom_range(99) < 12);
    endtask

    // drop valid and wait for every verdict still owed
    task automatic drain_verdicts();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // field extremes, every lead class and the named corner cases
    task automatic test_directed();
        byte_q_t str;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        noise_pct    = 0;
        str = {};                                  send_string(str, 1'b0); // empty string
        str = {8'h00, 8'h7F, 8'hC0, 8'h80};        send_string(str, 1'b0);
        str = {8'hDF, 8'hBF};                      send_string(str, 1'b0);
        str = {utf8v_pkg::ED_LEAD, 8'h9F, 8'hBF};  send_string(str, 1'b0); // ed, legal
        str = {utf8v_pkg::ED_LEAD, 8'hA0};         send_string(str, 1'b0); // ed, surrogate
        str = {8'hF7, 8'hBF, 8'hBF, 8'hBF};        send_string(str, 1'b0);
        str = {8'hFF};                             send_string(str, 1'b0); // bad lead
        str = {8'h80};                             send_string(str, 1'b0); // stray continuation
        str = {8'hC2, 8'h41};                      send_string(str, 1'b0); // missing continuation
        str = {8'hE0, 8'h80};                      send_string(str, 1'b0); // cut off
        str = {8'hC3};                             send_string(str, 1'b1); // cut off, byteless end
        send_beat(8'hFF, 1'b0, 1'b0);                                     // ignored beat
        str = {8'h41};                             send_string(str, 1'b1); // byteless end, valid
    endtask

    task automatic test_mixed_idling(input int target);
        tx_gap_pct   = 25;
        rx_stall_pct = 25;
        noise_pct    = 4;
        send_random_strings(target);
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int target);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        noise_pct    = 0;
        send_random_strings(target);
    endtask

    // receiver stops for a long while, sender keeps offering one-byte strings
    task automatic test_receiver_hold_off();
        byte_q_t str;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        noise_pct    = 0;
        hold_request = 300;
        repeat (40)
        begin
            str = {utf8v_pkg::byte_t'($urandom_range(255))};
            send_string(str, 1'b0);
        end
    endtask

    // sender goes quiet until every verdict is back, then resumes
    task automatic test_sender_pause();
        tx_gap_pct   = 10;
        rx_stall_pct = 40;
        noise_pct    = 0;
        repeat (4) send_string(random_string(), 1'b0);
        drain_verdicts();
        repeat (4) send_string(random_string(), 1'b0);
    endtask

    task automatic test_heavy_idling(input int target);
        tx_gap_pct   = 60;
        rx_stall_pct = 60;
        noise_pct    = 8;
        send_random_strings(target);
    endtask

    // ------------------------------------------------------------------
    // receiver and scoreboard: check the beat taken at this edge, then
    // decide ready for the next one
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        bit want;
        stall_left       = 0;
        verdict_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && verdict_ch.valid && verdict_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch($sformatf("verdict %b with no string pending",
                                              verdict_ch.string_valid));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict_ch.string_valid !== want)
                        report_mismatch($sformatf("string_valid expected %b actual %b",
                                                  want, verdict_ch.string_valid));
                end
            end
            if (!rst_n)
            begin
                verdict_ch.ready <= 1'b0;
            end
            else if (hold_request > 0)
            begin
                // long hold-off, counted down by one at each edge
                verdict_ch.ready <= 1'b0;
                hold_request--;
            end
            else if (stall_left > 0)
            begin
                verdict_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(99) < rx_stall_pct)
            begin
                verdict_ch.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
            begin
                verdict_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = '0;
        byte_ch.byte_present = 1'b0;
        byte_ch.string_end   = 1'b0;
        pend_count           = utf8v_pkg::PEND_NONE;
        ed_seen              = 1'b0;
        error_seen           = 1'b0;
        error_count          = 0;
        items_sent           = 0;
        hold_request         = 0;
        tx_gap_pct           = 0;
        rx_stall_pct         = 0;
        noise_pct            = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_mixed_idling(450);
        test_back_to_back(700);
        test_receiver_hold_off();
        test_sender_pause();
        test_heavy_idling(1050);

        // all beats taken; wait for the last verdicts and a little beyond
        drain_verdicts();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("utf8_stream_validator_unit_tb passed");
        else
            $display("utf8_stream_validator_unit_tb failed");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial
    begin
        #4000000;
        $display("utf8_stream_validator_unit_tb failed");
        $finish;
    end

endmodule

/* utf8_stream_validator_unit.f */
hdl/utf8v_pkg.sv
hdl/utf8v_byte_if.sv
hdl/utf8v_verdict_if.sv
hdl/utf8_stream_validator_unit.sv
tb/utf8_stream_validator_unit_tb.sv
